/* design/tfn_pkg.sv */
// Shared constants and types for the triangle face normal pipeline.
// No dependencies; every design file refers to it by scoped names.
package tfn_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = 30;   // magnitude width after normalization
  localparam int OUT_BITS         = 16;

  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int BLEN_W     = $clog2(CROSS_W + 1);
  localparam int SUM_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_STEPS = SUM_W / 2;          // also the width of the root
  localparam int ROOT_W     = SUM_W + 1;
  localparam int QUO_W      = NORMAL_FRAC_BITS + 1;
  localparam int REM_W      = ROOT_STEPS + QUO_W;

  localparam logic [31:0] POS_MAX = 32'((1 << (OUT_BITS - 1)) - 1);
  localparam logic [31:0] NEG_MAX = 32'(1 << (OUT_BITS - 1));

  typedef logic [2:0][NORM_BITS-1:0] mag3_t;
  typedef logic [2:0][QUO_W-1:0]     quo3_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } sign_t;

  typedef struct packed {
    mag3_t      mag;
    logic [2:0] neg;
    logic       degen;
  } norm_t;

endpackage

/* design/tfn_cross.sv */
// Front of the pipeline: edges, cross product, magnitude/sign and
// normalization of the largest magnitude to NORM_BITS bits. Uses tfn_pkg.
module tfn_cross (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_en,
  input  logic [8:0][tfn_pkg::COORD_BITS-1:0]    coord,
  output logic                                   out_valid,
  input  logic                                   out_en,
  output tfn_pkg::norm_t                         out_norm
);

  localparam int LAST = 4;

  logic [LAST:0] v_r;
  logic          en;

  logic signed [tfn_pkg::EDGE_W-1:0]  e_r   [6];
  logic signed [tfn_pkg::EDGE_W-1:0]  e_nxt [6];
  logic signed [tfn_pkg::PROD_W-1:0]  p_r   [6];
  logic signed [tfn_pkg::PROD_W-1:0]  p_nxt [6];
  logic [tfn_pkg::CROSS_W-1:0]        mag_r   [3];
  logic [tfn_pkg::CROSS_W-1:0]        mag_nxt [3];
  logic [2:0]                         neg_r, neg_nxt;
  logic [tfn_pkg::CROSS_W-1:0]        mag3_r [3];
  logic [2:0]                         neg3_r;
  logic [tfn_pkg::BLEN_W-1:0]         blen_r, blen_nxt;
  tfn_pkg::norm_t                     norm_r, norm_nxt;

  assign en        = !v_r[LAST] || out_en;
  assign in_en     = en;
  assign out_valid = v_r[LAST];
  assign out_norm  = norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_valid};
    end
  end

  // edges a = second - first, b = third - first
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_nxt[i]   = tfn_pkg::EDGE_W'($signed(coord[i + 3])) -
                   tfn_pkg::EDGE_W'($signed(coord[i]));
      e_nxt[i+3] = tfn_pkg::EDGE_W'($signed(coord[i + 6])) -
                   tfn_pkg::EDGE_W'($signed(coord[i]));
    end
  end

  always_comb begin
    p_nxt[0] = e_r[1] * e_r[5];
    p_nxt[1] = e_r[2] * e_r[4];
    p_nxt[2] = e_r[2] * e_r[3];
    p_nxt[3] = e_r[0] * e_r[5];
    p_nxt[4] = e_r[0] * e_r[4];
    p_nxt[5] = e_r[1] * e_r[3];
  end

  always_comb begin
    logic signed [tfn_pkg::CROSS_W-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c = tfn_pkg::CROSS_W'(p_r[2*i]) - tfn_pkg::CROSS_W'(p_r[2*i + 1]);
      neg_nxt[i] = c[tfn_pkg::CROSS_W-1];
      mag_nxt[i] = neg_nxt[i] ? tfn_pkg::CROSS_W'(-c) : tfn_pkg::CROSS_W'(c);
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    logic [tfn_pkg::CROSS_W-1:0] any;
    any      = mag_r[0] | mag_r[1] | mag_r[2];
    blen_nxt = '0;
    for (int i = 0; i < tfn_pkg::CROSS_W; i++) begin
      if (any[i]) blen_nxt = tfn_pkg::BLEN_W'(i + 1);
    end
  end

  // (mag << NORM_BITS) >> L covers both the exact left shift and the truncating right shift
  always_comb begin
    logic [tfn_pkg::CROSS_W+tfn_pkg::NORM_BITS-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = {mag3_r[i], tfn_pkg::NORM_BITS'(0)} >> blen_r;
      norm_nxt.mag[i] = wide[tfn_pkg::NORM_BITS-1:0];
    end
    norm_nxt.neg   = neg3_r;
    norm_nxt.degen = (blen_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r    <= e_nxt;
      p_r    <= p_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      mag3_r <= mag_r;
      neg3_r <= neg_r;
      blen_r <= blen_nxt;
      norm_r <= norm_nxt;
    end
  end

endmodule

/* design/tfn_sqrt.sv */
// Sum of squares and a pipelined integer square root, one result bit per stage.
// Uses tfn_pkg.
module tfn_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_en,
  input  tfn_pkg::norm_t                    in_norm,
  output logic                              out_valid,
  input  logic                              out_en,
  output tfn_pkg::norm_t                    out_norm,
  output logic [tfn_pkg::ROOT_STEPS-1:0]    out_len
);

  localparam int STEPS = tfn_pkg::ROOT_STEPS;
  localparam int LAST  = STEPS + 1;

  logic [LAST:0] v_r;
  logic          en;

  logic [2*tfn_pkg::NORM_BITS-1:0] sq_r   [3];
  logic [2*tfn_pkg::NORM_BITS-1:0] sq_nxt [3];
  logic [tfn_pkg::ROOT_W-1:0]      x_r    [STEPS];
  logic [tfn_pkg::ROOT_W-1:0]      x_nxt  [STEPS];
  logic [tfn_pkg::ROOT_W-1:0]      r_r    [STEPS+1];
  logic [tfn_pkg::ROOT_W-1:0]      r_nxt  [STEPS+1];
  tfn_pkg::norm_t                  nrm_r  [LAST+1];

  assign en        = !v_r[LAST] || out_en;
  assign in_en     = en;
  assign out_valid = v_r[LAST];
  assign out_norm  = nrm_r[LAST];
  assign out_len   = r_r[STEPS][STEPS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_valid};
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_nxt[l] = in_norm.mag[l] * in_norm.mag[l];
    end
  end

  always_comb begin
    logic [tfn_pkg::ROOT_W-1:0] bitv;
    logic [tfn_pkg::ROOT_W-1:0] t;
    x_nxt[0] = tfn_pkg::ROOT_W'(sq_r[0]) + tfn_pkg::ROOT_W'(sq_r[1]) +
               tfn_pkg::ROOT_W'(sq_r[2]);
    r_nxt[0] = '0;
    for (int k = 1; k <= STEPS; k++) begin
      bitv = tfn_pkg::ROOT_W'(1) << (2 * (STEPS - k));
      t    = r_r[k-1] + bitv;
      if (x_r[k-1] >= t) begin
        r_nxt[k] = (r_r[k-1] >> 1) + bitv;
        if (k < STEPS) x_nxt[k] = x_r[k-1] - t;
      end else begin
        r_nxt[k] = r_r[k-1] >> 1;
        if (k < STEPS) x_nxt[k] = x_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= sq_nxt;
      x_r      <= x_nxt;
      r_r      <= r_nxt;
      nrm_r[0] <= in_norm;
      for (int s = 1; s <= LAST; s++) begin
        nrm_r[s] <= nrm_r[s-1];
      end
    end
  end

endmodule

/* design/tfn_div.sv */
// Three-lane pipelined restoring divider: q = (m * 2^FRAC + len/2) / len,
// one quotient bit per stage. Uses tfn_pkg.
module tfn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_en,
  input  tfn_pkg::norm_t                    in_norm,
  input  logic [tfn_pkg::ROOT_STEPS-1:0]    in_len,
  output logic                              out_valid,
  input  logic                              out_en,
  output tfn_pkg::quo3_t                    out_quo,
  output tfn_pkg::sign_t                    out_sign
);

  localparam int LAST = tfn_pkg::QUO_W;

  logic [LAST:0] v_r;
  logic          en;

  logic [2:0][tfn_pkg::REM_W-1:0]      rem_r   [LAST];
  logic [2:0][tfn_pkg::REM_W-1:0]      rem_nxt [LAST];
  logic [tfn_pkg::ROOT_STEPS-1:0]      d_r     [LAST];
  tfn_pkg::quo3_t                      q_r     [LAST+1];
  tfn_pkg::quo3_t                      q_nxt   [LAST+1];
  tfn_pkg::sign_t                      sg_r    [LAST+1];

  assign en        = !v_r[LAST] || out_en;
  assign in_en     = en;
  assign out_valid = v_r[LAST];
  assign out_quo   = q_r[LAST];
  assign out_sign  = sg_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_valid};
    end
  end

  always_comb begin
    logic [tfn_pkg::REM_W-1:0] dv;
    int                        sh;
    for (int l = 0; l < 3; l++) begin
      rem_nxt[0][l] = tfn_pkg::REM_W'({in_norm.mag[l], tfn_pkg::NORMAL_FRAC_BITS'(0)}) +
                      tfn_pkg::REM_W'(in_len >> 1);
    end
    q_nxt[0] = '0;
    for (int k = 1; k <= LAST; k++) begin
      sh       = LAST - k;
      q_nxt[k] = q_r[k-1];
      dv       = tfn_pkg::REM_W'(d_r[k-1]) << sh;
      for (int l = 0; l < 3; l++) begin
        if (rem_r[k-1][l] >= dv) begin
          q_nxt[k][l][sh] = 1'b1;
          if (k < LAST) rem_nxt[k][l] = rem_r[k-1][l] - dv;
        end else begin
          if (k < LAST) rem_nxt[k][l] = rem_r[k-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      q_r      <= q_nxt;
      d_r[0]   <= in_len;
      sg_r[0]  <= '{neg: in_norm.neg, degen: in_norm.degen};
      for (int s = 1; s < LAST; s++) begin
        d_r[s] <= d_r[s-1];
      end
      for (int s = 1; s <= LAST; s++) begin
        sg_r[s] <= sg_r[s-1];
      end
    end
  end

endmodule

/* design/triangle_face_normal_unit.sv */
// Triangle face normal: top level with the output stage and assertions.
// Instantiates tfn_cross, tfn_sqrt and tfn_div; uses tfn_pkg.
//
// Usage: present one triangle (three vertices, signed 24-bit coordinates)
// on the in_ ports with in_valid; a beat is taken on a clock edge where
// in_valid is high and in_stall is low. Each triangle yields one result
// beat: a unit normal in signed Q2.14 and a degenerate flag (normal zero
// when the edges are parallel or a vertex repeats).
// From input beat to output beat a triangle passes edges/cross/normalize,
// squares and square root at one root bit per stage, the divider at one
// quotient bit per stage, and 1 output register. Throughput is one
// triangle per cycle while no stall holds the pipeline.
// Each section advances whenever its last stage is empty or the next
// section advances. Bubbles ahead of a blocked section's last stage are
// not squeezed out, so in_stall rises as soon as the front section's last
// stage holds a beat that the next section cannot take.
// Synchronous reset empties the pipeline; out_valid is low after it.
module triangle_face_normal_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_first_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_first_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_first_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_second_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_second_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_second_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_third_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_third_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_third_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tfn_pkg::OUT_BITS-1:0]  out_normal_x,
  output logic signed [tfn_pkg::OUT_BITS-1:0]  out_normal_y,
  output logic signed [tfn_pkg::OUT_BITS-1:0]  out_normal_z,
  output logic                                 out_degenerate
);

  logic [8:0][tfn_pkg::COORD_BITS-1:0] coord;
  logic                                cross_en, cross_valid;
  tfn_pkg::norm_t                      cross_norm;
  logic                                sqrt_en, sqrt_valid;
  tfn_pkg::norm_t                      sqrt_norm;
  logic [tfn_pkg::ROOT_STEPS-1:0]      sqrt_len;
  logic                                div_en, div_valid;
  tfn_pkg::quo3_t                      div_quo;
  tfn_pkg::sign_t                      div_sign;

  logic                                out_en;
  logic                                out_valid_r;
  logic [2:0][tfn_pkg::OUT_BITS-1:0]   nrm_r, nrm_nxt;
  logic                                degen_r;

  assign coord = {in_third_z, in_third_y, in_third_x,
                  in_second_z, in_second_y, in_second_x,
                  in_first_z, in_first_y, in_first_x};

  tfn_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_en     (cross_en),
    .coord     (coord),
    .out_valid (cross_valid),
    .out_en    (sqrt_en),
    .out_norm  (cross_norm)
  );

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cross_valid),
    .in_en     (sqrt_en),
    .in_norm   (cross_norm),
    .out_valid (sqrt_valid),
    .out_en    (div_en),
    .out_norm  (sqrt_norm),
    .out_len   (sqrt_len)
  );

  tfn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sqrt_valid),
    .in_en     (div_en),
    .in_norm   (sqrt_norm),
    .in_len    (sqrt_len),
    .out_valid (div_valid),
    .out_en    (out_en),
    .out_quo   (div_quo),
    .out_sign  (div_sign)
  );

  assign out_en   = !out_valid_r || !out_stall;
  assign in_stall = !cross_en;

  // apply sign, saturate to the field, force zero on degenerate
  always_comb begin
    logic [31:0] qx;
    logic [31:0] lim;
    for (int l = 0; l < 3; l++) begin
      qx = 32'(div_quo[l]);
      if (div_sign.neg[l]) begin
        lim        = (qx > tfn_pkg::NEG_MAX) ? tfn_pkg::NEG_MAX : qx;
        nrm_nxt[l] = tfn_pkg::OUT_BITS'(32'd0 - lim);
      end else begin
        lim        = (qx > tfn_pkg::POS_MAX) ? tfn_pkg::POS_MAX : qx;
        nrm_nxt[l] = tfn_pkg::OUT_BITS'(lim);
      end
      if (div_sign.degen) nrm_nxt[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      nrm_r   <= nrm_nxt;
      degen_r <= div_sign.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = $signed(nrm_r[0]);
  assign out_normal_y   = $signed(nrm_r[1]);
  assign out_normal_z   = $signed(nrm_r[2]);
  assign out_degenerate = degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate beat carries a nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("non-degenerate beat carries a zero normal");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* dv/tb_triangle_face_normal_unit.sv */
// Testbench for triangle_face_normal_unit: random and directed triangles,
// face normals predicted in a scoreboard class. Depends on tfn_pkg and the RTL.
module tb_triangle_face_normal_unit;

  typedef logic signed [tfn_pkg::COORD_BITS-1:0] coord_t;
  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } face_normal_t;

  class normal_scoreboard;
    face_normal_t pending[$];
    int errors = 0;

    function automatic logic [63:0] root64(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic face_normal_t compute_normal(coord_t v[9]);
      logic signed [127:0] ax, ay, az, bx, by, bz;
      logic signed [127:0] c[3];
      logic [127:0] mg[3];
      logic [63:0] m[3], s, len, q;
      logic neg[3];
      int blen, b;
      face_normal_t r;
      ax = v[3] - v[0]; ay = v[4] - v[1]; az = v[5] - v[2];
      bx = v[6] - v[0]; by = v[7] - v[1]; bz = v[8] - v[2];
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
      blen = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = c[i] < 0;
        mg[i] = neg[i] ? -c[i] : c[i];
        b = 0;
        for (int k = 0; k < 128; k++) if (mg[i][k]) b = k + 1;
        if (b > blen) blen = b;
      end
      r.degen = (blen == 0);
      r.nx = 0; r.ny = 0; r.nz = 0;
      if (r.degen) return r;
      for (int i = 0; i < 3; i++)
        m[i] = (blen > tfn_pkg::NORM_BITS) ? 64'(mg[i] >> (blen - tfn_pkg::NORM_BITS))
                                           : 64'(mg[i] << (tfn_pkg::NORM_BITS - blen));
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = root64(s);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << tfn_pkg::NORMAL_FRAC_BITS) + (len >> 1)) / len;
        if (neg[i]) begin
          if (q > 32768) q = 32768;
          q = -q;
        end else if (q > 32767) q = 32767;
        if (i == 0) r.nx = q[15:0];
        else if (i == 1) r.ny = q[15:0];
        else r.nz = q[15:0];
      end
      return r;
    endfunction

    function void note_triangle(coord_t v[9]);
      pending.push_back(compute_normal(v));
    endfunction

    function void check_normal(face_normal_t got);
      face_normal_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %0d %0d %0d %0b", $time,
                 got.nx, got.ny, got.nz, got.degen);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
          got.degen !== want.degen) begin
        $display("%0t: mismatch expected %0d %0d %0d %0b actual %0d %0d %0d %0b",
                 $time, want.nx, want.ny, want.nz, want.degen,
                 got.nx, got.ny, got.nz, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, out_degenerate;
  coord_t in_c[9];
  logic signed [tfn_pkg::OUT_BITS-1:0] out_normal_x, out_normal_y, out_normal_z;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  longint cycles = 0;
  normal_scoreboard sb = new();

  always #5 clk = ~clk;

  initial for (int i = 0; i < 9; i++) in_c[i] = '0;

  triangle_face_normal_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_first_x(in_c[0]), .in_first_y(in_c[1]), .in_first_z(in_c[2]),
    .in_second_x(in_c[3]), .in_second_y(in_c[4]), .in_second_z(in_c[5]),
    .in_third_x(in_c[6]), .in_third_y(in_c[7]), .in_third_z(in_c[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    face_normal_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.nx = out_normal_x; got.ny = out_normal_y; got.nz = out_normal_z;
      got.degen = out_degenerate;
      sb.check_normal(got);
    end
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive one beat; waits for acceptance, leaves in_valid high afterwards
  task automatic send_triangle(coord_t v[9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_c[i] <= v[i];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_triangle(v);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return coord_t'($signed($urandom_range(8000)) - 4000) <<< $urandom_range(12);
    endcase
  endfunction

  task automatic random_triangles(int n);
    coord_t v[9];
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(3);
      for (int i = 0; i < 9; i++) v[i] = rand_coord($urandom_range(4) == 0 ? 2 : mode);
      case ($urandom_range(9))
        0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];        // repeated vertex
        1: for (int i = 0; i < 3; i++) v[6 + i] = 2 * v[3 + i] - v[i]; // collinear
        default: ;
      endcase
      send_triangle(v);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  initial begin
    coord_t v[9];
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: axis triangles, extremes, degenerate cases
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);
    v = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; send_triangle(v);
    v = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
          24'h800000, 24'h7FFFFF, 24'h800000}; send_triangle(v);
    v = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
          24'h7FFFFF, 24'h7FFFFF, 24'h800000}; send_triangle(v);
    v = '{24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
          24'h800000, 24'h800000, 24'h7FFFFF}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 1, 0, 1}; send_triangle(v);
    v = '{0, 0, 0, 3, 0, 0, 0, 0, 3}; send_triangle(v);
    v = '{-1, -1, -1, 24'h7FFFFF, -1, -1, -1, 1, 24'h7FFFFF}; send_triangle(v);
    v = '{0, 0, 0, 1, 2, 3, 4, 5, 6}; send_triangle(v);
    send_idle = 38; recv_idle = 46;
    random_triangles(250);
    // long receiver hold-off while the sender keeps offering
    hold_recv = 1;
    fork
      random_triangles(120);
      begin repeat (300) @(posedge clk); hold_recv = 0; end
    join
    drain();   // sender pauses until every result is back
    send_idle = 46; recv_idle = 38;
    random_triangles(220);
    send_idle = 0; recv_idle = 0;
    random_triangles(200);
    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* files.f */
design/tfn_pkg.sv
design/tfn_cross.sv
design/tfn_sqrt.sv
design/tfn_div.sv
design/triangle_face_normal_unit.sv
dv/tb_triangle_face_normal_unit.sv
